// ===== hw/rtl/cwtq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwtq_pkg
// types and codes shared by the wake-up timer queue
// ----------------------------------------------------------------------------
package cwtq_pkg;

    localparam logic [1:0] OP_ATTACH = 2'd0;
    localparam logic [1:0] OP_DETACH = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [2:0] K_DONE     = 3'd0;
    localparam logic [2:0] K_WOKEN    = 3'd1;
    localparam logic [2:0] K_NONE_DUE = 3'd2;
    localparam logic [2:0] K_FULL     = 3'd3;
    localparam logic [2:0] K_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] task_id;
        logic [47:0] deadline;
        logic [47:0] now;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] woken_id;
        logic        waiting;
        logic        last;
    } t_out;

endpackage : cwtq_pkg
`default_nettype wire

// ===== hw/rtl/cwtq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwtq_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module cwtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [AW-1:0]             i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire  [AW-1:0]             i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/coalescing_wakeup_timer_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_wakeup_timer_queue_top
// wake-up timer queue: attach, detach, tick and query over point/member rams
// attach scans the points, then the members; detach the members, then the points;
// query the members only; tick the points, then, if one is due, the members
// of that point once for each woken id
// throughput: one item at a time, next transfer once the last result has left
// reset: valid bits clear at once, no clearing pass, merge window to 1000
// ----------------------------------------------------------------------------
module coalescing_wakeup_timer_queue_top #(
    parameter int POINTS  = 8,
    parameter int MEMBERS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  cwtq_pkg::t_in  i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output cwtq_pkg::t_out o_data,
    input  wire            i_cfg_we,
    input  wire  [31:0]    i_cfg_data
);
    import cwtq_pkg::*;

    localparam int PW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int MW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PSCAN  = 3'd1;
    localparam logic [2:0] S_MSCAN  = 3'd2;
    localparam logic [2:0] S_DSEL   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;
    localparam logic [2:0] S_WSCAN  = 3'd5;
    localparam logic [2:0] S_WOUT   = 3'd6;

    logic [2:0]         r_state;
    t_in                r_in;
    logic [31:0]        r_win;
    logic [POINTS-1:0]  r_pv;
    logic [MEMBERS-1:0] r_mv;
    logic [PW:0]        r_pc;
    logic [MW:0]        r_mc;
    logic               r_rv;
    logic [PW-1:0]      r_ra;
    logic [MW-1:0]      r_rma;
    logic               r_bf;
    logic [PW-1:0]      r_bp;
    logic [47:0]        r_bd;
    logic               r_hit;
    logic               r_wait;
    logic [POINTS-1:0]  r_dmask;
    logic [MW-1:0]      r_dmem [POINTS];
    logic [POINTS-1:0]  r_occ1;
    logic [POINTS-1:0]  r_occ2;
    logic               r_cand;
    logic [15:0]        r_cid;
    logic [MW-1:0]      r_cm;
    logic               r_more;
    t_out               r_out;
    logic               r_ov;
    t_out               n_out;

    logic             go;
    logic             p_we;
    logic [PW-1:0]    p_wa;
    logic [47:0]      p_rd;
    logic             m_we;
    logic [MW-1:0]    m_wa;
    logic [15+PW:0]   m_wd;
    logic [15+PW:0]   m_rd;
    logic [15:0]      m_task;
    logic [PW-1:0]    m_pt;
    logic [47:0]      dl_gap;
    logic             p_end;
    logic             m_end;

    assign m_task = m_rd[15+PW:PW];
    assign m_pt   = m_rd[PW-1:0];
    assign dl_gap = (p_rd > r_in.deadline) ? p_rd - r_in.deadline : r_in.deadline - p_rd;
    assign p_end  = (r_pc < (PW+1)'(POINTS));
    assign m_end  = (r_mc < (MW+1)'(MEMBERS));

    cwtq_ram #(.WIDTH(48), .DEPTH(POINTS)) u_pram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(r_in.deadline),
        .i_raddr(r_pc[PW-1:0]), .o_rdata(p_rd));
    cwtq_ram #(.WIDTH(16+PW), .DEPTH(MEMBERS)) u_mram (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(r_mc[MW-1:0]), .o_rdata(m_rd));

    logic          fp_f;
    logic [PW-1:0] fp_i;
    always_comb begin
        fp_f = 1'b0;
        fp_i = '0;
        for (int i = POINTS - 1; i >= 0; i--) begin
            if (!r_pv[i]) begin
                fp_f = 1'b1;
                fp_i = PW'(i);
            end
        end
    end

    logic          fm_f;
    logic [MW-1:0] fm_i;
    always_comb begin
        fm_f = 1'b0;
        fm_i = '0;
        for (int i = MEMBERS - 1; i >= 0; i--) begin
            if (!r_mv[i]) begin
                fm_f = 1'b1;
                fm_i = MW'(i);
            end
        end
    end

    assign go   = (r_state == S_RESULT) && !r_ov;
    assign p_wa = fp_i;
    assign m_wa = fm_i;
    assign m_wd = {r_in.task_id, r_bf ? r_bp : fp_i};

    always_comb begin
        p_we  = 1'b0;
        m_we  = 1'b0;
        n_out = '0;
        n_out.last = 1'b1;
        if (r_state == S_WOUT) begin
            n_out.kind     = r_cand ? K_WOKEN : K_NONE_DUE;
            n_out.woken_id = r_cand ? r_cid : 16'd0;
            n_out.last     = !(r_cand && r_more);
        end else begin
            case (r_in.opcode)
                OP_ATTACH: begin
                    if (!(r_bf && r_hit)) begin
                        if (!fm_f || (!r_bf && !fp_f)) begin
                            n_out.kind = K_FULL;
                        end else begin
                            m_we = go;
                            p_we = go && !r_bf;
                        end
                    end
                end
                OP_DETACH: begin
                    if (!r_bf) n_out.kind = K_NOTFOUND;
                end
                OP_TICK: begin
                    n_out.kind = K_NONE_DUE;
                end
                default: begin
                    n_out.waiting = r_wait;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= '0;
            r_mv    <= '0;
            r_ov    <= 1'b0;
            r_win   <= 32'd1000;
            r_rv    <= 1'b0;
        end else begin
            if (i_cfg_we) r_win <= i_cfg_data;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in    <= i_data;
                        r_pc    <= '0;
                        r_mc    <= '0;
                        r_rv    <= 1'b0;
                        r_bf    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_wait  <= 1'b0;
                        r_dmask <= '0;
                        r_occ1  <= '0;
                        r_occ2  <= '0;
                        r_cand  <= 1'b0;
                        r_more  <= 1'b0;
                        r_state <= (i_data.opcode == OP_ATTACH || i_data.opcode == OP_TICK)
                                   ? S_PSCAN : S_MSCAN;
                    end
                end
                S_PSCAN: begin
                    r_rv <= p_end;
                    r_ra <= r_pc[PW-1:0];
                    if (p_end) r_pc <= r_pc + 1'b1;
                    if (r_rv && r_pv[r_ra] && (!r_bf || p_rd < r_bd)
                        && ((r_in.opcode == OP_ATTACH) ? (dl_gap <= {16'd0, r_win})
                                                       : (p_rd <= r_in.now))) begin
                        r_bf <= 1'b1;
                        r_bp <= r_ra;
                        r_bd <= p_rd;
                    end
                    if (!r_rv && !p_end) begin
                        if (r_in.opcode == OP_ATTACH) begin
                            r_state <= S_MSCAN;
                        end else if (r_bf) begin
                            r_state <= S_WSCAN;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_MSCAN: begin
                    r_rv  <= m_end;
                    r_rma <= r_mc[MW-1:0];
                    if (m_end) r_mc <= r_mc + 1'b1;
                    if (r_rv && r_mv[r_rma]) begin
                        r_occ1[m_pt] <= 1'b1;
                        r_occ2[m_pt] <= r_occ1[m_pt];
                        if (m_task == r_in.task_id) begin
                            r_wait <= 1'b1;
                            if (r_bf && m_pt == r_bp) r_hit <= 1'b1;
                            if (r_pv[m_pt]) begin
                                r_dmask[m_pt] <= 1'b1;
                                r_dmem[m_pt]  <= r_rma;
                            end
                        end
                    end
                    if (!r_rv && !m_end) begin
                        r_state <= (r_in.opcode == OP_DETACH) ? S_DSEL : S_RESULT;
                    end
                end
                S_DSEL: begin
                    // earliest point holding the task, lowest index on a tie
                    r_rv <= p_end;
                    r_ra <= r_pc[PW-1:0];
                    if (p_end) r_pc <= r_pc + 1'b1;
                    if (r_rv && r_dmask[r_ra] && (!r_bf || p_rd < r_bd)) begin
                        r_bf <= 1'b1;
                        r_bp <= r_ra;
                        r_bd <= p_rd;
                    end
                    if (!r_rv && !p_end) r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_ov) begin
                        r_ov  <= 1'b1;
                        r_out <= n_out;
                        if (m_we) r_mv[fm_i] <= 1'b1;
                        if (p_we) r_pv[fp_i] <= 1'b1;
                        if (r_in.opcode == OP_DETACH && r_bf) begin
                            r_mv[r_dmem[r_bp]] <= 1'b0;
                            if (!r_occ2[r_bp]) r_pv[r_bp] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_WSCAN: begin
                    // smallest remaining id of the woken point
                    r_rv  <= m_end;
                    r_rma <= r_mc[MW-1:0];
                    if (m_end) r_mc <= r_mc + 1'b1;
                    if (r_rv && r_mv[r_rma] && m_pt == r_bp) begin
                        if (!r_cand || m_task < r_cid) begin
                            r_cid <= m_task;
                            r_cm  <= r_rma;
                        end
                        r_cand <= 1'b1;
                        if (r_cand) r_more <= 1'b1;
                    end
                    if (!r_rv && !m_end) r_state <= S_WOUT;
                end
                S_WOUT: begin
                    if (!r_ov) begin
                        r_ov  <= 1'b1;
                        r_out <= n_out;
                        if (r_cand) r_mv[r_cm] <= 1'b0;
                        if (r_cand && r_more) begin
                            r_mc    <= '0;
                            r_rv    <= 1'b0;
                            r_cand  <= 1'b0;
                            r_more  <= 1'b0;
                            r_state <= S_WSCAN;
                        end else begin
                            r_pv[r_bp] <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/coalescing_wakeup_timer_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_wakeup_timer_queue_top_tb
// wake-up timer queue: random and directed attach/detach/tick/query traffic,
// each result checked in order against a behavioural timer-queue predictor
// ----------------------------------------------------------------------------
module coalescing_wakeup_timer_queue_top_tb;
    import cwtq_pkg::*;

    localparam int NPT = 8;
    localparam int NMB = 16;

    class wake_scoreboard;
        logic [47:0] pt_dl[NPT];
        bit          pt_on[NPT];
        logic [15:0] mb_task[NMB];
        int          mb_pt[NMB];
        bit          mb_on[NMB];
        logic [31:0] window;
        t_out        pending[$];
        int          errors;

        function void clear();
            foreach (pt_on[p]) pt_on[p] = 0;
            foreach (mb_on[m]) mb_on[m] = 0;
            window = 32'd1000;
            errors = 0;
            pending.delete();
        endfunction

        function void push(logic [2:0] k, logic [15:0] id, bit w, bit l);
            t_out r;
            r.kind = k; r.woken_id = id; r.waiting = w; r.last = l;
            pending.insert(pending.size(), r);
        endfunction

        function logic [2:0] attach(logic [15:0] tk, logic [47:0] dl);
            int best, fm, fp;
            logic [47:0] d;
            best = -1; fm = -1; fp = -1;
            for (int p = 0; p < NPT; p++) begin
                if (!pt_on[p]) continue;
                d = pt_dl[p] > dl ? pt_dl[p] - dl : dl - pt_dl[p];
                if (d <= {16'd0, window} && (best < 0 || pt_dl[p] < pt_dl[best])) best = p;
            end
            for (int m = NMB - 1; m >= 0; m--) if (!mb_on[m]) fm = m;
            if (best >= 0) begin
                for (int m = 0; m < NMB; m++)
                    if (mb_on[m] && mb_task[m] == tk && mb_pt[m] == best) return K_DONE;
                if (fm < 0) return K_FULL;
            end else begin
                for (int p = NPT - 1; p >= 0; p--) if (!pt_on[p]) fp = p;
                if (fp < 0 || fm < 0) return K_FULL;
                best = fp;
                pt_on[fp] = 1;
                pt_dl[fp] = dl;
            end
            mb_on[fm] = 1; mb_task[fm] = tk; mb_pt[fm] = best;
            return K_DONE;
        endfunction

        function logic [2:0] detach(logic [15:0] tk);
            int best, bm, p;
            bit gone;
            best = -1; bm = -1;
            for (int m = 0; m < NMB; m++) begin
                if (!mb_on[m] || mb_task[m] != tk) continue;
                p = mb_pt[m];
                if (!pt_on[p]) continue;
                if (best < 0 || pt_dl[p] < pt_dl[best] ||
                    (p < best && pt_dl[p] == pt_dl[best])) begin
                    best = p; bm = m;
                end
            end
            if (bm < 0) return K_NOTFOUND;
            mb_on[bm] = 0;
            gone = 1;
            for (int m = 0; m < NMB; m++) if (mb_on[m] && mb_pt[m] == best) gone = 0;
            if (gone) pt_on[best] = 0;
            return K_DONE;
        endfunction

        function void tick(logic [47:0] now);
            int best, n, j;
            logic [15:0] ids[NMB];
            logic [15:0] v;
            best = -1;
            n = 0;
            for (int p = 0; p < NPT; p++)
                if (pt_on[p] && pt_dl[p] <= now && (best < 0 || pt_dl[p] < pt_dl[best]))
                    best = p;
            if (best < 0) begin
                push(K_NONE_DUE, 16'd0, 1'b0, 1'b1);
                return;
            end
            for (int m = 0; m < NMB; m++)
                if (mb_on[m] && mb_pt[m] == best) begin
                    v = mb_task[m];
                    j = n;
                    while (j > 0 && ids[j - 1] > v) begin
                        ids[j] = ids[j - 1];
                        j--;
                    end
                    ids[j] = v;
                    n++;
                    mb_on[m] = 0;
                end
            pt_on[best] = 0;
            if (n == 0) push(K_NONE_DUE, 16'd0, 1'b0, 1'b1);
            for (int i = 0; i < n; i++) push(K_WOKEN, ids[i], 1'b0, i == n - 1);
        endfunction

        function void note_input(t_in it);
            bit w;
            case (it.opcode)
                OP_ATTACH: push(attach(it.task_id, it.deadline), 16'd0, 1'b0, 1'b1);
                OP_DETACH: push(detach(it.task_id), 16'd0, 1'b0, 1'b1);
                OP_TICK:   tick(it.now);
                default: begin
                    w = 0;
                    for (int m = 0; m < NMB; m++)
                        if (mb_on[m] && mb_task[m] == it.task_id) w = 1;
                    push(K_DONE, 16'd0, w, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind || got.woken_id !== exp_r.woken_id ||
                got.waiting !== exp_r.waiting || got.last !== exp_r.last) begin
                $display("%0t mismatch: expected kind %0d id %h wait %b last %b, actual kind %0d id %h wait %b last %b",
                         $time, exp_r.kind, exp_r.woken_id, exp_r.waiting, exp_r.last,
                         got.kind, got.woken_id, got.waiting, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 0;
    t_out        o_data;
    logic        i_cfg_we = 0;
    logic [31:0] i_cfg_data = '0;

    wake_scoreboard sb;
    logic [15:0] tid_pool[8];
    logic [47:0] clock_now;
    bit          stall_on = 1;

    always #5 i_clk = ~i_clk;

    coalescing_wakeup_timer_queue_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    // receiver stalls in a drifting pattern, with stretches of no stalls
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
        i_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    task automatic send(t_in it);
        i_data  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(it);
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [1:0] op, logic [15:0] tk, logic [47:0] dl, logic [47:0] nw);
        t_in it;
        it.opcode = op; it.task_id = tk; it.deadline = dl; it.now = nw;
        send(it);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (NPT + NMB * NMB + 40) @(negedge i_clk);
    endtask

    task automatic set_window(logic [31:0] w);
        drain();
        i_cfg_data <= w;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.window = w;
    endtask

    task automatic random_item();
        t_in it;
        int r;
        r = $urandom_range(0, 99);
        it.task_id  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : tid_pool[$urandom_range(0, 7)];
        it.deadline = clock_now + $urandom_range(0, 20000);
        if ($urandom_range(0, 19) == 0) it.deadline = 48'({$urandom, $urandom});
        it.now      = clock_now;
        if (r < 45)      it.opcode = OP_ATTACH;
        else if (r < 60) it.opcode = OP_DETACH;
        else if (r < 80) begin
            it.opcode = OP_TICK;
            clock_now = clock_now + $urandom_range(0, 6000);
            it.now = clock_now;
            if ($urandom_range(0, 29) == 0) it.now = 48'({$urandom, $urandom});
        end else         it.opcode = OP_QUERY;
        send(it);
    endtask

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int gap;
        bit held;
        sb = new();
        sb.clear();
        foreach (tid_pool[i]) tid_pool[i] = 16'($urandom);
        tid_pool[0] = 16'h0000;
        tid_pool[1] = 16'hFFFF;
        clock_now = 48'd100_000;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: edges, merging, duplicate, full tables, not found, nothing due
        send_op(OP_TICK, 16'h1234, 48'h0, 48'hFFFF_FFFF_FFFF);
        send_op(OP_DETACH, 16'hFFFF, 48'h0, 48'h0);
        send_op(OP_ATTACH, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0);
        send_op(OP_ATTACH, 16'h0000, 48'hFFFF_FFFF_FC18, 48'h0);
        send_op(OP_ATTACH, 16'h0000, 48'hFFFF_FFFF_FC18, 48'h0);
        send_op(OP_ATTACH, 16'h0005, 48'hFFFF_FFFF_FC17, 48'h0);
        send_op(OP_QUERY, 16'hFFFF, 48'h0, 48'h0);
        send_op(OP_QUERY, 16'h0001, 48'h0, 48'h0);
        send_op(OP_ATTACH, 16'h0007, 48'h0, 48'h0);
        send_op(OP_DETACH, 16'h0007, 48'h0, 48'h0);
        send_op(OP_TICK, 16'h0, 48'h0, 48'h0);
        send_op(OP_TICK, 16'h0, 48'h0, 48'hFFFF_FFFF_FFFF);
        send_op(OP_TICK, 16'h0, 48'h0, 48'hFFFF_FFFF_FFFF);
        set_window(32'd0);
        for (int i = 0; i < 9; i++) send_op(OP_ATTACH, 16'(i), 48'(i * 10), 48'h0);
        for (int i = 0; i < 9; i++) send_op(OP_ATTACH, 16'(100 + i), 48'd0, 48'h0);
        send_op(OP_TICK, 16'h0, 48'h0, 48'h0);
        for (int i = 0; i < 8; i++) send_op(OP_TICK, 16'h0, 48'h0, 48'hFFFF_FFFF_FFFF);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_window(32'hFFFF_FFFF);
                1: set_window(32'd1000);
                2: set_window(32'($urandom_range(0, 5000)));
                default: set_window(32'd0);
            endcase
            held = 0;
            for (int n = 0; n < 95;) begin
                for (int b = $urandom_range(1, 12); b > 0 && n < 95; b--) begin
                    random_item();
                    n++;
                end
                if (n >= 45 && !held) begin
                    held = 1;
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                repeat (gap) @(negedge i_clk);
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== coalescing_wakeup_timer_queue_top.f =====
hw/rtl/cwtq_pkg.sv
hw/rtl/cwtq_ram.sv
hw/rtl/coalescing_wakeup_timer_queue_top.sv
tb/sv/coalescing_wakeup_timer_queue_top_tb.sv
